[sv/stq_pkg.sv]
// Shared types and codes for the sorted task queue.
// Holds operation codes, result status codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package stq_pkg;

   // Operation codes on the request func port.
   localparam logic [2:0] FN_ABS    = 3'd0;
   localparam logic [2:0] FN_DELAY  = 3'd1;
   localparam logic [2:0] FN_FRONT  = 3'd2;
   localparam logic [2:0] FN_REMOVE = 3'd3;
   localparam logic [2:0] FN_POP    = 3'd4;

   // Result status codes.
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_REMOVED   = 3'd3;
   localparam logic [2:0] ST_POPPED    = 3'd4;
   localparam logic [2:0] ST_NONE      = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;         // capture the request operands
      logic       load_delay;   // due time is now plus the delay
      logic       compare;      // register per-cell compare vectors
      logic       apply_timed;  // ordered insert
      logic       apply_front;  // insert at head with time zero
      logic       apply_pop;    // drop the head entry
      logic       rot_step;     // one rotation step of a remove
      logic       reply;        // load the result registers
      logic [2:0] status;       // status code of the result
   } stq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic dup;
      logic head_due;
      logic rot_done;
   } stq_sts_type;

endpackage

[sv/stq_ctrl.sv]
// Controller state machine of the sorted task queue.
// Sequences compare, update and remove rotation; depends on stq_pkg.
`timescale 1ns / 1ps

module stq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_func,
   output logic                 busy,
   output logic                 rsp_valid,
   output stq_pkg::stq_cmd_type cmd,
   input  stq_pkg::stq_sts_type sts
);
   import stq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_APPLY,
      S_ROTATE
   } state_type;

   state_type  state_ff, state_in;
   logic       busy_ff, busy_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] func_ff, func_in;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      func_in      = func_ff;
      cmd          = '0;
      cmd.status   = ST_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load       = 1'b1;
               cmd.load_delay = (req_func == FN_DELAY);
               func_in        = req_func;
               busy_in        = 1'b1;
               state_in       = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = (func_ff == FN_REMOVE) ? S_ROTATE : S_APPLY;
         end
         S_APPLY: begin
            case (func_ff) inside
               FN_ABS, FN_DELAY: begin
                  if (sts.full) begin
                     cmd.status = ST_FULL;
                  end else if (sts.dup) begin
                     cmd.status = ST_DUPLICATE;
                  end else begin
                     cmd.status      = ST_INSERTED;
                     cmd.apply_timed = 1'b1;
                  end
               end
               FN_FRONT: begin
                  if (sts.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.status      = ST_INSERTED;
                     cmd.apply_front = 1'b1;
                  end
               end
               FN_POP: begin
                  if (sts.head_due) begin
                     cmd.status    = ST_POPPED;
                     cmd.apply_pop = 1'b1;
                  end
               end
               default: begin
                  cmd.status = ST_NONE;
               end
            endcase
            cmd.reply    = 1'b1;
            rsp_valid_in = 1'b1;
            busy_in      = 1'b0;
            state_in     = S_IDLE;
         end
         S_ROTATE: begin
            if (sts.rot_done) begin
               cmd.status   = ST_REMOVED;
               cmd.reply    = 1'b1;
               rsp_valid_in = 1'b1;
               busy_in      = 1'b0;
               state_in     = S_IDLE;
            end else begin
               cmd.rot_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         func_ff      <= FN_ABS;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         func_ff      <= func_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   // A result always closes the transaction, so the block is free while it shows.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("result strobe while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (busy_ff && state_ff == S_COMPARE))
      else $error("accepted request did not enter compare");

   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != S_IDLE))
      else $error("busy flag disagrees with state");

endmodule

[sv/stq_dp.sv]
// Datapath of the sorted task queue: a chain of entry cells with local compare.
// Cells shift left, right or load the new entry under controller commands; depends on stq_pkg.
`timescale 1ns / 1ps

module stq_dp #(
   parameter int CAPACITY = 16,
   parameter int ID_BITS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  stq_pkg::stq_cmd_type         cmd,
   output stq_pkg::stq_sts_type         sts,
   input  logic [ID_BITS-1:0]           req_task_id,
   input  logic [31:0]                  req_time_value,
   input  logic [31:0]                  req_now_ms,
   output logic [2:0]                   rsp_status,
   output logic [ID_BITS-1:0]           rsp_popped_id,
   output logic [31:0]                  rsp_popped_time,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_removed_count,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_pending_count
);
   import stq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Entry cells.
   logic [31:0]        cell_time_ff [CAPACITY];
   logic [31:0]        cell_time_in [CAPACITY];
   logic [ID_BITS-1:0] cell_id_ff   [CAPACITY];
   logic [ID_BITS-1:0] cell_id_in   [CAPACITY];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rot_left_ff, rot_left_in;
   logic [CNT_W-1:0]   removed_ff, removed_in;
   logic [ID_BITS-1:0] tgt_id_ff, tgt_id_in;
   logic [31:0]        tgt_time_ff, tgt_time_in;
   logic [31:0]        now_ff, now_in;
   logic [CAPACITY-1:0] le_ff, le_in;
   logic [CAPACITY-1:0] hit_ff, hit_in;
   logic               head_due_ff, head_due_in;
   logic [2:0]         status_ff, status_in;
   logic [ID_BITS-1:0] pid_ff, pid_in;
   logic [31:0]        ptime_ff, ptime_in;
   logic [CNT_W-1:0]   tail;
   logic               head_match;

   assign tail       = count_ff - CNT_W'(1);
   assign head_match = (cell_id_ff[0] == tgt_id_ff);

   // Per-cell compare: entry is live and due no later than the new time.
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         le_in[k]  = (CNT_W'(k) < count_ff) && (cell_time_ff[k] <= tgt_time_ff);
         hit_in[k] = le_in[k] && (cell_id_ff[k] == tgt_id_ff);
      end
      head_due_in = (count_ff != '0) && (cell_time_ff[0] <= now_ff);
   end

   // Cell update. Because the entries are sorted, le_ff is a run of ones from
   // the head, so each cell finds its own role from itself and its neighbor.
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         cell_time_in[k] = cell_time_ff[k];
         cell_id_in[k]   = cell_id_ff[k];
         if (cmd.apply_front) begin
            if (k == 0) begin
               cell_time_in[k] = '0;
               cell_id_in[k]   = tgt_id_ff;
            end else begin
               cell_time_in[k] = cell_time_ff[k-1];
               cell_id_in[k]   = cell_id_ff[k-1];
            end
         end else if (cmd.apply_timed) begin
            if (k == 0) begin
               if (!le_ff[0]) begin
                  cell_time_in[k] = tgt_time_ff;
                  cell_id_in[k]   = tgt_id_ff;
               end
            end else begin
               if (le_ff[k-1] && !le_ff[k]) begin
                  cell_time_in[k] = tgt_time_ff;
                  cell_id_in[k]   = tgt_id_ff;
               end else if (!le_ff[k-1]) begin
                  cell_time_in[k] = cell_time_ff[k-1];
                  cell_id_in[k]   = cell_id_ff[k-1];
               end
            end
         end else if (cmd.apply_pop || cmd.rot_step) begin
            if (k < CAPACITY - 1) begin
               cell_time_in[k] = cell_time_ff[k+1];
               cell_id_in[k]   = cell_id_ff[k+1];
            end
            // A kept head wraps around to the tail of the live entries.
            if (cmd.rot_step && !head_match && (CNT_W'(k) == tail)) begin
               cell_time_in[k] = cell_time_ff[0];
               cell_id_in[k]   = cell_id_ff[0];
            end
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      rot_left_in = rot_left_ff;
      removed_in  = removed_ff;
      tgt_id_in   = tgt_id_ff;
      tgt_time_in = tgt_time_ff;
      now_in      = now_ff;
      status_in   = status_ff;
      pid_in      = pid_ff;
      ptime_in    = ptime_ff;
      if (cmd.load) begin
         tgt_id_in   = req_task_id;
         tgt_time_in = cmd.load_delay ? (req_now_ms + req_time_value) : req_time_value;
         now_in      = req_now_ms;
         rot_left_in = count_ff;
         removed_in  = '0;
      end
      if (cmd.apply_timed || cmd.apply_front) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.apply_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.rot_step) begin
         rot_left_in = rot_left_ff - CNT_W'(1);
         if (head_match) begin
            count_in   = count_ff - CNT_W'(1);
            removed_in = removed_ff + CNT_W'(1);
         end
      end
      if (cmd.reply) begin
         status_in = cmd.status;
         pid_in    = cmd.apply_pop ? cell_id_ff[0] : '0;
         ptime_in  = cmd.apply_pop ? cell_time_ff[0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_time_ff <= cell_time_in;
      cell_id_ff   <= cell_id_in;
      rot_left_ff  <= rot_left_in;
      removed_ff   <= removed_in;
      tgt_id_ff    <= tgt_id_in;
      tgt_time_ff  <= tgt_time_in;
      now_ff       <= now_in;
      status_ff    <= status_in;
      pid_ff       <= pid_in;
      ptime_ff     <= ptime_in;
      if (cmd.compare) begin
         le_ff       <= le_in;
         hit_ff      <= hit_in;
         head_due_ff <= head_due_in;
      end
   end

   assign sts.full     = (count_ff == CNT_W'(CAPACITY));
   assign sts.dup      = |hit_ff;
   assign sts.head_due = head_due_ff;
   assign sts.rot_done = (rot_left_ff == '0);

   assign rsp_status        = status_ff;
   assign rsp_popped_id     = pid_ff;
   assign rsp_popped_time   = ptime_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_pending_count = count_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.apply_pop |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not shorten the queue");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply_timed || cmd.apply_front) |-> (count_ff != CNT_W'(CAPACITY)))
      else $error("insert into a full queue");

endmodule

[sv/sorted_task_queue.sv]
// Top level of the sorted task queue: controller plus cell-chain datapath.
// Depends on stq_pkg, stq_ctrl and stq_dp.
`timescale 1ns / 1ps
// Inserts, pops and unused codes pass through the compare and apply states before
// the registered result strobe; a remove instead steps through the rotation that
// passes every entry once through the head cell. The block handles one transaction
// at a time; busy drops in the strobe cycle and the receiver cannot stall, so results
// never back up.
// Reset (synchronous, active high) empties the queue and idles the controller.

module sorted_task_queue #(
   parameter int CAPACITY = 16,
   parameter int ID_BITS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_func,
   input  logic [ID_BITS-1:0]            req_task_id,
   input  logic [31:0]                   req_time_value,
   input  logic [31:0]                   req_now_ms,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [ID_BITS-1:0]            rsp_popped_id,
   output logic [31:0]                   rsp_popped_time,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_removed_count,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_pending_count
);
   import stq_pkg::*;

   // The controller and the datapath talk only through these two structs.
   stq_cmd_type cmd;
   stq_sts_type sts;

   // The controller sequences each transaction: capture, compare all cells
   // at once, then either an update or a rotation for a remove.
   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the ordered entries in a chain of cells; each cell
   // compares itself with the request and moves in step with its neighbors.
   stq_dp #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_task_id       (req_task_id),
      .req_time_value    (req_time_value),
      .req_now_ms        (req_now_ms),
      .rsp_status        (rsp_status),
      .rsp_popped_id     (rsp_popped_id),
      .rsp_popped_time   (rsp_popped_time),
      .rsp_removed_count (rsp_removed_count),
      .rsp_pending_count (rsp_pending_count)
   );

endmodule

[sim/sorted_task_queue_tb.sv]
// Self-checking testbench for the sorted task queue: directed corner cases, then random traffic.
// A shadow copy of the queue predicts every reply; depends on stq_pkg and sorted_task_queue.
`timescale 1ns / 1ps

module sorted_task_queue_tb;
   import stq_pkg::*;

   localparam int CAPACITY        = 16;
   localparam int ID_BITS         = 8;
   localparam int CNT_BITS        = $clog2(CAPACITY + 1);
   // A remove of a full queue is the slowest transaction, and the sender's random
   // gaps are short, so a long quiet stretch means a hang.
   localparam int STALL_LIMIT     = 2000;
   localparam int ITEMS_PER_PHASE = 500;
   localparam int TAIL_CYCLES     = 30;

   // One reply of the block, field for field as it appears on the rsp_ ports.
   typedef struct packed {
      logic [2:0]          status;
      logic [ID_BITS-1:0]  popped_id;
      logic [31:0]         popped_time;
      logic [CNT_BITS-1:0] removed_count;
      logic [CNT_BITS-1:0] pending_count;
   } queue_reply_type;

   // Shadow of the queue contents. Each accepted transaction is applied to the
   // shadow at once, and the reply it must produce is queued until the block
   // delivers it; the block answers strictly in order, one reply per transaction.
   class task_queue_shadow;
      logic [31:0]        due_time[CAPACITY];
      logic [ID_BITS-1:0] due_id[CAPACITY];
      int                 held;
      int                 peak_held;
      queue_reply_type    awaited[$];
      int unsigned        mismatches;
      int unsigned        checked;
      int unsigned        kind_count[8];

      function new();
         held = 0;
         peak_held = 0;
         mismatches = 0;
         checked = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function void note_request(logic [2:0] func, logic [ID_BITS-1:0] id,
                                 logic [31:0] tv, logic [31:0] now);
         queue_reply_type r;
         logic [31:0]     due;
         int              pos;
         int              k;
         int              w;
         int              n;
         r = '0;
         r.status = ST_NONE;
         case (func)
            FN_ABS, FN_DELAY: begin
               // Delayed due times wrap modulo 2^32 and then sort as plain unsigned.
               due = (func == FN_DELAY) ? now + tv : tv;
               if (held >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  // The new entry goes behind every entry due at or before it;
                  // the same id among those entries makes it a duplicate.
                  r.status = ST_INSERTED;
                  pos = 0;
                  while (pos < held && due_time[pos] <= due) begin
                     if (due_id[pos] == id) r.status = ST_DUPLICATE;
                     pos++;
                  end
                  if (r.status == ST_INSERTED) begin
                     for (k = held; k > pos; k--) begin
                        due_time[k] = due_time[k-1];
                        due_id[k] = due_id[k-1];
                     end
                     due_time[pos] = due;
                     due_id[pos] = id;
                     held++;
                  end
               end
            end
            FN_FRONT: begin
               if (held >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  for (k = held; k > 0; k--) begin
                     due_time[k] = due_time[k-1];
                     due_id[k] = due_id[k-1];
                  end
                  due_time[0] = '0;
                  due_id[0] = id;
                  held++;
                  r.status = ST_INSERTED;
               end
            end
            FN_REMOVE: begin
               w = 0;
               n = 0;
               for (k = 0; k < held; k++) begin
                  if (due_id[k] == id) begin
                     n++;
                  end else begin
                     due_time[w] = due_time[k];
                     due_id[w] = due_id[k];
                     w++;
                  end
               end
               held = w;
               r.status = ST_REMOVED;
               r.removed_count = CNT_BITS'(n);
            end
            FN_POP: begin
               if (held > 0 && due_time[0] <= now) begin
                  r.status = ST_POPPED;
                  r.popped_id = due_id[0];
                  r.popped_time = due_time[0];
                  for (k = 1; k < held; k++) begin
                     due_time[k-1] = due_time[k];
                     due_id[k-1] = due_id[k];
                  end
                  held--;
               end
            end
            default: ;
         endcase
         r.pending_count = CNT_BITS'(held);
         if (held > peak_held) peak_held = held;
         kind_count[r.status]++;
         awaited.push_back(r);
      endfunction

      function void check_reply(queue_reply_type got);
         queue_reply_type want;
         if (awaited.size() == 0) begin
            $error("reply with no transaction outstanding: status %0d", got.status);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.popped_id !== want.popped_id) begin
            $error("popped_id: expected %0d, got %0d", want.popped_id, got.popped_id);
            mismatches++;
         end
         if (got.popped_time !== want.popped_time) begin
            $error("popped_time: expected %0h, got %0h", want.popped_time, got.popped_time);
            mismatches++;
         end
         if (got.removed_count !== want.removed_count) begin
            $error("removed_count: expected %0d, got %0d",
                   want.removed_count, got.removed_count);
            mismatches++;
         end
         if (got.pending_count !== want.pending_count) begin
            $error("pending_count: expected %0d, got %0d",
                   want.pending_count, got.pending_count);
            mismatches++;
         end
      endfunction
   endclass

   // Every input starts at a known value; reset is held from time zero.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [2:0]          req_func = FN_POP;
   logic [ID_BITS-1:0]  req_task_id = '0;
   logic [31:0]         req_time_value = '0;
   logic [31:0]         req_now_ms = '0;
   logic                busy;
   logic                rsp_valid;
   logic [2:0]          rsp_status;
   logic [ID_BITS-1:0]  rsp_popped_id;
   logic [31:0]         rsp_popped_time;
   logic [CNT_BITS-1:0] rsp_removed_count;
   logic [CNT_BITS-1:0] rsp_pending_count;

   task_queue_shadow shadow = new();
   int               idle_pct = 0;      // chance in percent that the sender idles a cycle
   int               quiet_cycles = 0;  // cycles since the last handshake or reply
   int unsigned      items_sent = 0;
   logic [31:0]      uptime = '0;       // running millisecond clock for random traffic

   initial forever #5 clock = ~clock;

   sorted_task_queue #(
      .CAPACITY(CAPACITY),
      .ID_BITS (ID_BITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_task_id      (req_task_id),
      .req_time_value   (req_time_value),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_popped_id    (rsp_popped_id),
      .rsp_popped_time  (rsp_popped_time),
      .rsp_removed_count(rsp_removed_count),
      .rsp_pending_count(rsp_pending_count)
   );

   // The receiver cannot stall, so every strobed reply is taken at the edge
   // that ends its cycle and compared with the oldest outstanding prediction.
   always @(posedge clock) begin
      queue_reply_type got;
      if (!reset && rsp_valid) begin
         got.status = rsp_status;
         got.popped_id = rsp_popped_id;
         got.popped_time = rsp_popped_time;
         got.removed_count = rsp_removed_count;
         got.pending_count = rsp_pending_count;
         shadow.check_reply(got);
      end
   end

   // Hang detector: any request handshake or reply restarts the count.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction or reply for %0d cycles.", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offers one transaction and returns at the edge that accepts it. Start stays
   // high across back-to-back transactions; it only drops for random idle
   // cycles, so it is never lowered and raised in the same time step.
   task automatic issue(input logic [2:0] f, input logic [ID_BITS-1:0] id,
                        input logic [31:0] tv, input logic [31:0] now);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 50) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_task_id <= id;
      req_time_value <= tv;
      req_now_ms <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.note_request(f, id, tv, now);
      items_sent++;
   endtask

   // Holds the sender off until every outstanding reply has come back. The
   // first edge is always waited for, so a following issue never reassigns
   // start in the same time step.
   task automatic wait_for_replies();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.awaited.size() != 0) @(posedge clock);
   endtask

   // Random traffic. Ids mostly come from a small pool so duplicates and
   // multi-entry removes are common; due times mostly sit just ahead of the
   // running clock so pops find due entries. Every 40 transactions the mix
   // is picked at random between filling the queue (reaching the full case) and draining it.
   task automatic run_phase(input int pct, input int count);
      int                 pick;
      bit                 filling;
      logic [2:0]         f;
      logic [ID_BITS-1:0] id;
      logic [31:0]        tv;
      logic [31:0]        now;
      idle_pct = pct;
      filling = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) filling = $urandom_range(1);
         uptime += 32'($urandom_range(40));
         now = uptime;
         id = ($urandom_range(3) == 0) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(11));
         tv = 32'($urandom_range(300));
         pick = $urandom_range(99);
         if (pick < (filling ? 70 : 30)) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               f = FN_ABS;
               tv = uptime + tv;
            end else if (pick < 85) begin
               f = FN_DELAY;
            end else begin
               f = FN_FRONT;
            end
            // Now and then a due time or delay anywhere in the 32-bit range,
            // which also produces wrapped sums for delayed inserts.
            if ($urandom_range(9) == 0) tv = $urandom;
         end else if (pick < (filling ? 80 : 55)) begin
            f = FN_REMOVE;
         end else if (pick < 97) begin
            f = FN_POP;
            if ($urandom_range(9) == 0) now = $urandom;
         end else begin
            // Unused operation codes with random operands.
            f = 3'(FN_POP + 1 + $urandom_range(2));
            id = ID_BITS'($urandom);
            tv = $urandom;
            now = $urandom;
         end
         issue(f, id, tv, now);
      end
      wait_for_replies();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 8;

      // Directed part. Pop and remove on an empty queue, then the unused codes.
      issue(FN_POP, 8'd0, 32'd0, 32'hFFFF_FFFF);
      issue(FN_REMOVE, 8'd0, 32'd0, 32'd0);
      for (int f = FN_POP + 1; f < 8; f++) issue(3'(f), 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Extreme due times, and a delayed insert whose sum wraps to 0x10.
      issue(FN_ABS, 8'hFF, 32'hFFFF_FFFF, 32'd0);
      issue(FN_ABS, 8'h00, 32'd0, 32'd0);
      issue(FN_DELAY, 8'h01, 32'h20, 32'hFFFF_FFF0);
      // Duplicates: same id at the latest time, and same id at an equal time.
      issue(FN_ABS, 8'hFF, 32'hFFFF_FFFF, 32'd0);
      issue(FN_DELAY, 8'h00, 32'd0, 32'd0);
      // Pop of a due head, then a pop where the head is not yet due.
      issue(FN_POP, 8'd0, 32'd0, 32'd0);
      issue(FN_POP, 8'd0, 32'd0, 32'h0000_000F);

      // Fill to capacity with front inserts of one id (no duplicate check there),
      // then every kind of insert must be refused as full.
      repeat (CAPACITY - 2) issue(FN_FRONT, 8'd7, 32'hFFFF_FFFF, 32'd0);
      issue(FN_ABS, 8'd9, 32'd5, 32'd0);
      issue(FN_DELAY, 8'd9, 32'd5, 32'd0);
      issue(FN_FRONT, 8'd9, 32'd0, 32'd0);
      // A remove that deletes many entries, then pop the rest with the latest now.
      issue(FN_REMOVE, 8'd7, 32'd0, 32'd0);
      issue(FN_POP, 8'd0, 32'd0, 32'hFFFF_FFFF);
      issue(FN_POP, 8'd0, 32'd0, 32'hFFFF_FFFF);
      wait_for_replies();

      // Random part in three phases: light sender idling, heavy idling, none.
      // The second phase runs the clock across the 32-bit wrap.
      uptime = $urandom;
      run_phase(8, ITEMS_PER_PHASE);
      uptime = 32'hFFFF_F000;
      run_phase(47, ITEMS_PER_PHASE);
      run_phase(0, ITEMS_PER_PHASE);

      // Let any stray reply show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.awaited.size() != 0) begin
         $error("%0d replies never arrived", shadow.awaited.size());
         shadow.mismatches++;
      end

      $display("Ran %0d transactions, %0d replies checked, peak occupancy %0d of %0d.",
               items_sent, shadow.checked, shadow.peak_held, CAPACITY);
      $display("Inserted %0d, duplicate %0d, full %0d, removed %0d, popped %0d, none %0d.",
               shadow.kind_count[ST_INSERTED], shadow.kind_count[ST_DUPLICATE],
               shadow.kind_count[ST_FULL], shadow.kind_count[ST_REMOVED],
               shadow.kind_count[ST_POPPED], shadow.kind_count[ST_NONE]);
      if (shadow.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
